// ----- rtl/core/mhdsvc_pkg.sv -----
`timescale 1ns / 1ps

package mhdsvc_pkg;

	// Width of the signed working word for the wide sums (holds every term with margin).
	localparam int WIDE_W = 66;

	// Clip level of the wide kinetic and product terms.
	localparam logic [63:0] CAP62 = 64'h4000_0000_0000_0000;

	localparam int GMO_W = 18;
	localparam int IGM_W = 31;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [GMO_W-1:0] GMO_RESET = GMO_W'(43691);
	localparam logic [IGM_W-1:0] IGM_RESET = IGM_W'(98304);

	typedef enum logic {
		OP_CONS_TO_PRIM = 1'b0,
		OP_PRIM_TO_CONS = 1'b1
	} op_t;

	typedef enum logic {
		REG_GAMMA_M1     = 1'b0,
		REG_INV_GAMMA_M1 = 1'b1
	} reg_idx_t;

endpackage

// ----- rtl/core/mhd_state_variable_converter.sv -----
`timescale 1ns / 1ps

// MHD state-variable converter. Each transfer carries one grid point in signed
// fixed point (FRAC_BITS fraction bits) and is turned into its conserved or
// primitive counterpart, as the operation field selects. busy never rises, so a
// new transfer may be started in every clock cycle. Each result comes out on
// the result ports for exactly one cycle, flagged by done. The pipeline depth is
// set by the two bit-serial division pipelines (one quotient bit per stage), where
// OPB is min(WORD_BITS, 32): the velocity divider is OPB+FRAC_BITS stages deep,
// the kinetic energy divider 2*OPB stages deep. Results leave in the order their
// transfers came in, and the receiver cannot hold them off. Zero density on the
// conserved to primitive direction gives all-zero values with zero_density set.
// Values that overflow the word range saturate and raise saturated. The user
// must write the two coefficients through the APB port only while no transfer
// is in flight; the block itself does not enforce this.
module mhd_state_variable_converter #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mhdsvc_pkg::ADDR_W-1:0]    paddr,
	input  logic [mhdsvc_pkg::DATA_W-1:0]    pwdata,
	output logic [mhdsvc_pkg::DATA_W-1:0]    prdata,
	output logic                             pready,
	input  logic                             start,
	output logic                             busy,
	input  logic                             operation,
	input  logic [31:0]                      density,
	input  logic [31:0]                      x_in,
	input  logic [31:0]                      y_in,
	input  logic [31:0]                      z_in,
	input  logic [31:0]                      field_x,
	input  logic [31:0]                      field_y,
	input  logic [31:0]                      field_z,
	input  logic [31:0]                      energy_or_pressure_in,
	output logic                             done,
	output logic [31:0]                      x_out,
	output logic [31:0]                      y_out,
	output logic [31:0]                      z_out,
	output logic [31:0]                      energy_or_pressure_out,
	output logic                             zero_density,
	output logic                             saturated
);

	localparam int IW   = mhdsvc_pkg::WIDE_W;
	localparam int GW   = mhdsvc_pkg::GMO_W;
	localparam int GIW  = mhdsvc_pkg::IGM_W;
	localparam int OPB  = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int MW   = OPB;                    // magnitude width, holds 2^(OPB-1)
	localparam int QNW  = OPB + FRAC_BITS;        // velocity divider numerator
	localparam int SQW  = 2 * OPB;                // sum of three squares
	localparam int PW   = MW + SQW;               // density times sum of squares
	localparam int IMW  = FRAC_BITS + OPB + 1;    // clamped pressure operand
	localparam int GPW  = IMW + GW;
	localparam int T_Q  = 1 + QNW;
	localparam int T_K  = 3 + SQW;
	localparam int T0   = (T_Q > T_K) ? T_Q : T_K;
	localparam int LAT  = T0 + 4;
	localparam int DQ   = T0 - T_Q;
	localparam int DK   = T0 - T_K;
	localparam int DB   = T0 - 5;

	localparam logic signed [IW-1:0] OUT_MAX = IW'((64'sd1 <<< (OPB - 1)) - 64'sd1);
	localparam logic signed [IW-1:0] OUT_MIN = -OUT_MAX - IW'(1);
	localparam logic [IW-1:0]        CAP_W   = IW'(mhdsvc_pkg::CAP62);

	// Values carried alongside the dividers to the point where both paths meet.
	typedef struct packed {
		logic            op;
		logic            rneg;
		logic            rzero;
		logic [2:0]      aneg;
		logic [IW-1:0]   e;
		logic [IW-1:0]   bhalf;
		logic [IW-1:0]   q1_0;
		logic [IW-1:0]   q1_1;
		logic [IW-1:0]   q1_2;
		logic [IW-1:0]   pterm;
		logic [IW-1:0]   kin1;
	} carry_t;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [GW-1:0]  gmo_q;
	logic [GIW-1:0] igm_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmo_q <= mhdsvc_pkg::GMO_RESET;
			igm_q <= mhdsvc_pkg::IGM_RESET;
		end else if (cfg_wr) begin
			unique case (mhdsvc_pkg::reg_idx_t'(paddr[2]))
				mhdsvc_pkg::REG_GAMMA_M1:     gmo_q <= pwdata[GW-1:0];
				mhdsvc_pkg::REG_INV_GAMMA_M1: igm_q <= pwdata[GIW-1:0];
				default:                      gmo_q <= gmo_q;
			endcase
		end
	end

	always_comb begin
		unique case (mhdsvc_pkg::reg_idx_t'(paddr[2]))
			mhdsvc_pkg::REG_GAMMA_M1:     prdata = mhdsvc_pkg::DATA_W'(gmo_q);
			mhdsvc_pkg::REG_INV_GAMMA_M1: prdata = mhdsvc_pkg::DATA_W'(igm_q);
			default:                      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Valid bits. The pipeline never stalls, so one shift register tracks
	// which stages hold a live transfer.
	// ------------------------------------------------------------------
	logic           accept;
	logic [LAT-1:0] vld_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: take the low OPB bits of each field, split sign and magnitude.
	// ------------------------------------------------------------------
	logic [31:0]           a_raw [3];
	logic [31:0]           b_raw [3];
	logic signed [IW-1:0]  a_ext [3];
	logic signed [IW-1:0]  b_ext [3];
	logic signed [IW-1:0]  r_ext;
	logic signed [IW-1:0]  e_ext;

	assign a_raw[0] = x_in;
	assign a_raw[1] = y_in;
	assign a_raw[2] = z_in;
	assign b_raw[0] = field_x;
	assign b_raw[1] = field_y;
	assign b_raw[2] = field_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_ext[k] = IW'(signed'(a_raw[k][OPB-1:0]));
			b_ext[k] = IW'(signed'(b_raw[k][OPB-1:0]));
		end
		r_ext = IW'(signed'(density[OPB-1:0]));
		e_ext = IW'(signed'(energy_or_pressure_in[OPB-1:0]));
	end

	logic          op_s1, rneg_s1, rzero_s1;
	logic [MW-1:0] rm_s1, em_s1;
	logic [MW-1:0] am_s1 [3];
	logic [MW-1:0] bm_s1 [3];
	logic [2:0]    aneg_s1;
	logic [IW-1:0] e_s1;

	always_ff @(posedge clk) begin
		op_s1    <= operation;
		rneg_s1  <= r_ext[IW-1];
		rzero_s1 <= (r_ext == '0);
		rm_s1    <= MW'(r_ext[IW-1] ? -r_ext : r_ext);
		em_s1    <= MW'(e_ext[IW-1] ? -e_ext : e_ext);
		e_s1     <= e_ext;
		for (int k = 0; k < 3; k++) begin
			am_s1[k]   <= MW'(a_ext[k][IW-1] ? -a_ext[k] : a_ext[k]);
			bm_s1[k]   <= MW'(b_ext[k][IW-1] ? -b_ext[k] : b_ext[k]);
			aneg_s1[k] <= a_ext[k][IW-1];
		end
	end

	// Velocity dividers: (|m| << FRAC_BITS) / |rho|, one per axis.
	logic [QNW-1:0] qd_raw [3];

	for (genvar k = 0; k < 3; k++) begin : g_vdiv
		mhdsvc_div_pipe #(
			.NW(QNW),
			.DW(MW)
		) u_div (
			.clk (clk),
			.num ({am_s1[k], {FRAC_BITS{1'b0}}}),
			.den (rm_s1),
			.quo (qd_raw[k])
		);
	end

	// ------------------------------------------------------------------
	// Stage 2: the squares, the momentum products and the pressure-coefficient product.
	// ------------------------------------------------------------------
	logic [2*MW-1:0]    sqa_s2 [3];
	logic [2*MW-1:0]    sqb_s2 [3];
	logic [2*MW-1:0]    pa_s2  [3];
	logic [MW+GIW-1:0]  pe_s2;
	logic               op_s2, rneg_s2, rzero_s2;
	logic [MW-1:0]      rm_s2;
	logic [2:0]         aneg_s2;
	logic [IW-1:0]      e_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sqa_s2[k] <= am_s1[k] * am_s1[k];
			sqb_s2[k] <= bm_s1[k] * bm_s1[k];
			pa_s2[k]  <= am_s1[k] * rm_s1;
		end
		pe_s2    <= (MW+GIW)'(em_s1) * (MW+GIW)'(igm_q);
		op_s2    <= op_s1;
		rneg_s2  <= rneg_s1;
		rzero_s2 <= rzero_s1;
		rm_s2    <= rm_s1;
		aneg_s2  <= aneg_s1;
		e_s2     <= e_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: sums of squares, scaled momenta and pressure term.
	// ------------------------------------------------------------------
	logic [SQW-1:0] sq_s3, bb_s3;
	logic [IW-1:0]  q1_s3 [3];
	logic [IW-1:0]  pterm_s3;
	logic           op_s3, rneg_s3, rzero_s3;
	logic [MW-1:0]  rm_s3;
	logic [2:0]     aneg_s3;
	logic [IW-1:0]  e_s3;
	logic [IW-1:0]  q1_mag [3];
	logic [IW-1:0]  pt_mag;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			q1_mag[k] = IW'(pa_s2[k] >> FRAC_BITS);
		end
		pt_mag = IW'(pe_s2 >> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		sq_s3 <= SQW'(sqa_s2[0]) + SQW'(sqa_s2[1]) + SQW'(sqa_s2[2]);
		bb_s3 <= SQW'(sqb_s2[0]) + SQW'(sqb_s2[1]) + SQW'(sqb_s2[2]);
		for (int k = 0; k < 3; k++) begin
			q1_s3[k] <= (aneg_s2[k] != rneg_s2) ? -q1_mag[k] : q1_mag[k];
		end
		pterm_s3 <= e_s2[IW-1] ? -pt_mag : pt_mag;
		op_s3    <= op_s2;
		rneg_s3  <= rneg_s2;
		rzero_s3 <= rzero_s2;
		rm_s3    <= rm_s2;
		aneg_s3  <= aneg_s2;
		e_s3     <= e_s2;
	end

	// Kinetic divider: |m|^2 / (2 |rho|).
	logic [SQW-1:0] kq_raw;

	mhdsvc_div_pipe #(
		.NW(SQW),
		.DW(MW + 1)
	) u_kdiv (
		.clk (clk),
		.num (sq_s3),
		.den ({rm_s3, 1'b0}),
		.quo (kq_raw)
	);

	// ------------------------------------------------------------------
	// Stages 4 and 5: |rho| * |v|^2 as two 32x32 halves, then shift and clip.
	// ------------------------------------------------------------------
	logic [MW+OPB-1:0]     kp_lo_s4;
	logic [MW+SQW-OPB-1:0] kp_hi_s4;
	carry_t                cr_s4;

	always_ff @(posedge clk) begin
		kp_lo_s4   <= (MW+OPB)'(rm_s3) * (MW+OPB)'(sq_s3[OPB-1:0]);
		kp_hi_s4   <= (MW+SQW-OPB)'(rm_s3) * (MW+SQW-OPB)'(sq_s3[SQW-1:OPB]);
		cr_s4.op    <= op_s3;
		cr_s4.rneg  <= rneg_s3;
		cr_s4.rzero <= rzero_s3;
		cr_s4.aneg  <= aneg_s3;
		cr_s4.e     <= e_s3;
		cr_s4.bhalf <= IW'(bb_s3 >> (FRAC_BITS + 1));
		cr_s4.q1_0  <= q1_s3[0];
		cr_s4.q1_1  <= q1_s3[1];
		cr_s4.q1_2  <= q1_s3[2];
		cr_s4.pterm <= pterm_s3;
		cr_s4.kin1  <= '0;
	end

	logic [PW-1:0] kprod, ksh;
	logic [IW-1:0] kin1_mag;
	carry_t        cr_s5_d;
	carry_t        cr_s5;

	always_comb begin
		kprod        = (PW'(kp_hi_s4) << OPB) + PW'(kp_lo_s4);
		ksh          = kprod >> (2 * FRAC_BITS + 1);
		kin1_mag     = (|(ksh >> 62)) ? CAP_W : IW'(ksh);
		cr_s5_d      = cr_s4;
		cr_s5_d.kin1 = cr_s4.rneg ? -kin1_mag : kin1_mag;
	end

	always_ff @(posedge clk) begin
		cr_s5 <= cr_s5_d;
	end

	// ------------------------------------------------------------------
	// Align the three paths at the end of the longer divider.
	// ------------------------------------------------------------------
	carry_t         cr_t0;
	logic [QNW-1:0] qd_t0 [3];
	logic [SQW-1:0] kq_t0;

	mhdsvc_delay #(
		.WIDTH($bits(carry_t)),
		.DEPTH(DB)
	) u_dly_carry (
		.clk  (clk),
		.din  (cr_s5),
		.dout (cr_t0)
	);

	for (genvar k = 0; k < 3; k++) begin : g_vdly
		mhdsvc_delay #(
			.WIDTH(QNW),
			.DEPTH(DQ)
		) u_dly (
			.clk  (clk),
			.din  (qd_raw[k]),
			.dout (qd_t0[k])
		);
	end

	mhdsvc_delay #(
		.WIDTH(SQW),
		.DEPTH(DK)
	) u_dly_kin (
		.clk  (clk),
		.din  (kq_raw),
		.dout (kq_t0)
	);

	// ------------------------------------------------------------------
	// Stage A: energy balance and selection of the three vector results.
	// ------------------------------------------------------------------
	logic [IW-1:0]        km_mag, kin0;
	logic signed [IW-1:0] inner, total;
	logic [IW-1:0]        inner_mag;
	logic [IW-1:0]        q0 [3];
	logic [IW-1:0]        q1 [3];
	logic [IW-1:0]        q0_mag [3];

	always_comb begin
		km_mag = (|(kq_t0 >> 62)) ? CAP_W : IW'(kq_t0);
		kin0   = cr_t0.rneg ? -km_mag : km_mag;
		inner  = signed'(cr_t0.e) - signed'(kin0) - signed'(cr_t0.bhalf);
		total  = signed'(cr_t0.pterm) + signed'(cr_t0.kin1) + signed'(cr_t0.bhalf);
		inner_mag = inner[IW-1] ? -inner : inner;
		q1[0] = cr_t0.q1_0;
		q1[1] = cr_t0.q1_1;
		q1[2] = cr_t0.q1_2;
		for (int k = 0; k < 3; k++) begin
			q0_mag[k] = IW'(qd_t0[k]);
			q0[k] = (cr_t0.aneg[k] != cr_t0.rneg) ? -q0_mag[k] : q0_mag[k];
		end
	end

	logic           op_sa, rzero_sa, ineg_sa;
	logic [IMW-1:0] im_sa;
	logic [IW-1:0]  r_sa [3];
	logic [IW-1:0]  tot_sa;

	always_ff @(posedge clk) begin
		op_sa    <= cr_t0.op;
		rzero_sa <= cr_t0.rzero;
		ineg_sa  <= inner[IW-1];
		// Beyond 2^(FRAC_BITS+OPB) the pressure saturates for any nonzero
		// gamma-1, so the operand is clamped there to keep the multiply narrow.
		if (|(inner_mag >> (FRAC_BITS + OPB))) begin
			im_sa <= IMW'(1) << (FRAC_BITS + OPB);
		end else begin
			im_sa <= IMW'(inner_mag);
		end
		for (int k = 0; k < 3; k++) begin
			r_sa[k] <= (cr_t0.op == mhdsvc_pkg::OP_PRIM_TO_CONS) ? q1[k] : q0[k];
		end
		tot_sa <= total;
	end

	// ------------------------------------------------------------------
	// Stage B: pressure product in two partial products.
	// ------------------------------------------------------------------
	logic [OPB+GW-1:0]         gp_lo_sb;
	logic [IMW-OPB+GW-1:0]     gp_hi_sb;
	logic                      op_sb, rzero_sb, ineg_sb;
	logic [IW-1:0]             r_sb [3];
	logic [IW-1:0]             tot_sb;

	always_ff @(posedge clk) begin
		gp_lo_sb <= (OPB+GW)'(im_sa[OPB-1:0]) * (OPB+GW)'(gmo_q);
		gp_hi_sb <= (IMW-OPB+GW)'(im_sa[IMW-1:OPB]) * (IMW-OPB+GW)'(gmo_q);
		op_sb    <= op_sa;
		rzero_sb <= rzero_sa;
		ineg_sb  <= ineg_sa;
		r_sb     <= r_sa;
		tot_sb   <= tot_sa;
	end

	// ------------------------------------------------------------------
	// Stage C: combine the product and pick the scalar result.
	// ------------------------------------------------------------------
	logic [GPW-1:0] gprod;
	logic [IW-1:0]  pm, pval;

	always_comb begin
		gprod = (GPW'(gp_hi_sb) << OPB) + GPW'(gp_lo_sb);
		pm    = IW'(gprod >> FRAC_BITS);
		pval  = ineg_sb ? -pm : pm;
	end

	logic          op_sc, rzero_sc;
	logic [IW-1:0] r_sc [4];

	always_ff @(posedge clk) begin
		op_sc    <= op_sb;
		rzero_sc <= rzero_sb;
		r_sc[0]  <= r_sb[0];
		r_sc[1]  <= r_sb[1];
		r_sc[2]  <= r_sb[2];
		r_sc[3]  <= (op_sb == mhdsvc_pkg::OP_PRIM_TO_CONS) ? tot_sb : pval;
	end

	// ------------------------------------------------------------------
	// Stage D: saturate to the word range and register the result.
	// ------------------------------------------------------------------
	logic [31:0] clip_val [4];
	logic [3:0]  clip_hit;
	logic        zd;

	always_comb begin
		zd = (op_sc == mhdsvc_pkg::OP_CONS_TO_PRIM) && rzero_sc;
		for (int k = 0; k < 4; k++) begin
			if (signed'(r_sc[k]) > OUT_MAX) begin
				clip_val[k] = OUT_MAX[31:0];
				clip_hit[k] = 1'b1;
			end else if (signed'(r_sc[k]) < OUT_MIN) begin
				clip_val[k] = OUT_MIN[31:0];
				clip_hit[k] = 1'b1;
			end else begin
				clip_val[k] = r_sc[k][31:0];
				clip_hit[k] = 1'b0;
			end
		end
	end

	logic [31:0] res_sd [4];
	logic        zd_sd, sat_sd;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			res_sd[k] <= zd ? '0 : clip_val[k];
		end
		zd_sd  <= zd;
		sat_sd <= ~zd & (|clip_hit);
	end

	assign done                   = vld_q[LAT-1];
	assign x_out                  = res_sd[0];
	assign y_out                  = res_sd[1];
	assign z_out                  = res_sd[2];
	assign energy_or_pressure_out = res_sd[3];
	assign zero_density           = zd_sd;
	assign saturated              = sat_sd;

endmodule

// ----- rtl/core/mhdsvc_delay.sv -----
`timescale 1ns / 1ps

module mhdsvc_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	if (DEPTH == 0) begin : g_none
		assign dout = din;
	end else begin : g_line
		logic [WIDTH-1:0] tap_q [DEPTH];

		always_ff @(posedge clk) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end

		assign dout = tap_q[DEPTH-1];
	end

endmodule

// ----- rtl/core/mhdsvc_div_pipe.sv -----
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per register stage.
module mhdsvc_div_pipe #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [NW-1:0] nq_s  [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [DW-1:0] den_s [NW+1];

	assign nq_s[0]  = num;
	assign rem_s[0] = '0;
	assign den_s[0] = den;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] trial;
		logic        fits;

		assign trial = {rem_s[i], nq_s[i][NW-1]};
		assign fits  = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			nq_s[i+1]  <= {nq_s[i][NW-2:0], fits};
			rem_s[i+1] <= fits ? DW'(trial - {1'b0, den_s[i]}) : trial[DW-1:0];
			den_s[i+1] <= den_s[i];
		end
	end

	assign quo = nq_s[NW];

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the MHD state-variable converter. Grid points are sent as
// transfers on the start/busy port, and every transfer is run through a
// fixed-point predictor here as well. The predicted point goes into a FIFO.
// A monitor compares each done strobe against the oldest prediction.
// The coefficients are written over APB only while the pipeline is empty.
module tb_top;

	localparam int FRAC = 16;
	localparam int LATENCY = 71;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int WW = mhdsvc_pkg::WIDE_W;

	typedef struct packed {
		logic [31:0] xv;
		logic [31:0] yv;
		logic [31:0] zv;
		logic [31:0] ep;
		logic        zd;
		logic        sat;
	} point_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [mhdsvc_pkg::ADDR_W-1:0] paddr;
	logic [mhdsvc_pkg::DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic start, busy, operation;
	logic [31:0] density, x_in, y_in, z_in, field_x, field_y, field_z, energy_or_pressure_in;
	logic done, zero_density, saturated;
	logic [31:0] x_out, y_out, z_out, energy_or_pressure_out;

	mhd_state_variable_converter DUT (.*);

	// The predictor keeps its own copy of the two coefficients.
	logic [mhdsvc_pkg::GMO_W-1:0] gmo_copy;
	logic [mhdsvc_pkg::IGM_W-1:0] igm_copy;
	point_t expected_points[$];
	int errors;
	longint cycles;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Magnitude of a 64-bit signed value, as unsigned.
	function automatic logic [63:0] magn(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Exact (a*b) >> sh, clipped to 2^62.
	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		return p > {64'd0, mhdsvc_pkg::CAP62} ? mhdsvc_pkg::CAP62 : p[63:0];
	endfunction

	function automatic logic [31:0] clip32(input logic signed [WW-1:0] v,
			inout logic sat);
		if (v > 66'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -66'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic point_t convert_point(input mhdsvc_pkg::op_t op,
			input logic [31:0] rho_raw, input logic [31:0] av[3], input logic [31:0] bv[3],
			input logic [31:0] e_raw);
		logic signed [63:0] rho, e, ak, inner;
		logic [63:0] rm, sq, bb, q, km;
		logic signed [WW-1:0] res[4];
		logic signed [WW-1:0] bhalf, kin, pterm;
		logic neg;
		point_t r;
		rho = 64'(signed'(rho_raw));
		e = 64'(signed'(e_raw));
		rm = magn(rho);
		sq = 0;
		bb = 0;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			sq += magn(64'(signed'(av[k]))) * magn(64'(signed'(av[k])));
			bb += magn(64'(signed'(bv[k]))) * magn(64'(signed'(bv[k])));
		end
		bhalf = WW'(bb >> (FRAC + 1));
		if (op == mhdsvc_pkg::OP_CONS_TO_PRIM) begin
			if (rho == 0) begin
				r.zd = 1'b1;
				return r;
			end
			for (int k = 0; k < 3; k++) begin
				ak = 64'(signed'(av[k]));
				q = (magn(ak) << FRAC) / rm;
				neg = (ak < 0) != (rho < 0);
				res[k] = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
			end
			km = sq / (rm << 1);
			if (km > mhdsvc_pkg::CAP62) km = mhdsvc_pkg::CAP62;
			kin = (rho < 0) ? -$signed({2'b0, km}) : $signed({2'b0, km});
			inner = 64'(WW'(e) - kin - bhalf);
			q = scaled_product(magn(inner), 64'(gmo_copy), FRAC);
			res[3] = (inner < 0) ? -$signed({2'b0, q}) : $signed({2'b0, q});
		end else begin
			for (int k = 0; k < 3; k++) begin
				ak = 64'(signed'(av[k]));
				q = (magn(ak) * rm) >> FRAC;
				neg = (ak < 0) != (rho < 0);
				res[k] = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
			end
			q = scaled_product(magn(e), 64'(igm_copy), FRAC);
			pterm = (e < 0) ? -$signed({2'b0, q}) : $signed({2'b0, q});
			q = scaled_product(rm, sq, 2 * FRAC + 1);
			kin = (rho < 0) ? -$signed({2'b0, q}) : $signed({2'b0, q});
			res[3] = pterm + kin + bhalf;
		end
		r.xv = clip32(res[0], r.sat);
		r.yv = clip32(res[1], r.sat);
		r.zv = clip32(res[2], r.sat);
		r.ep = clip32(res[3], r.sat);
		return r;
	endfunction

	// Sends one grid point; it is taken at the first rising edge with busy low.
	task automatic send_point(input mhdsvc_pkg::op_t op, input logic [31:0] rho,
			input logic [31:0] xi, input logic [31:0] yi, input logic [31:0] zi,
			input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
			input logic [31:0] ep);
		logic [31:0] av[3], bv[3];
		av = '{xi, yi, zi};
		bv = '{bx, by, bz};
		start <= 1'b1;
		operation <= op;
		density <= rho;
		x_in <= xi;
		y_in <= yi;
		z_in <= zi;
		field_x <= bx;
		field_y <= by;
		field_z <= bz;
		energy_or_pressure_in <= ep;
		do @(posedge clk); while (busy);
		expected_points.push_back(convert_point(op, rho, av, bv, ep));
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Waits for the pipeline to empty; since every transfer gives a result, the
	// queue empties at the strobe of the last one, and the latency margin follows.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (expected_points.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_coeff(input mhdsvc_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mhdsvc_pkg::ADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == mhdsvc_pkg::REG_GAMMA_M1) gmo_copy = value[mhdsvc_pkg::GMO_W-1:0];
		else igm_copy = value[mhdsvc_pkg::IGM_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 65535 * 8)) - 32'sd262144);
			2: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7fffffff;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic logic [31:0] rand_density();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'($signed(-$urandom_range(1, 1 << 20)));
			default: return $urandom_range(1 << 12, 1 << 20);
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] ext[4] = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hffffffff};
		send_point(mhdsvc_pkg::OP_CONS_TO_PRIM, 32'h10000, 32'h20000, 32'hfffe0000, 32'h8000,
			32'h10000, 32'h0, 32'h0, 32'h80000);
		send_point(mhdsvc_pkg::OP_PRIM_TO_CONS, 32'h10000, 32'h20000, 32'hfffe0000, 32'h8000,
			32'h10000, 32'h0, 32'h0, 32'h10000);
		// Zero density in each direction.
		send_point(mhdsvc_pkg::OP_CONS_TO_PRIM, 32'h0, 32'h12345, 32'h1, 32'h2, 32'h3, 32'h4,
			32'h5, 32'h6);
		send_point(mhdsvc_pkg::OP_PRIM_TO_CONS, 32'h0, 32'h12345, 32'h1, 32'h2, 32'h3, 32'h4,
			32'h5, 32'h6);
		// Negative density.
		send_point(mhdsvc_pkg::OP_CONS_TO_PRIM, 32'hffff0000, 32'h30000, 32'h1, 32'hfff00000,
			32'h100, 32'h200, 32'h300, 32'h40000);
		send_point(mhdsvc_pkg::OP_PRIM_TO_CONS, 32'hffff0000, 32'h30000, 32'h1, 32'hfff00000,
			32'h100, 32'h200, 32'h300, 32'h40000);
		// Extremes of every field, including wide kinetic terms that clip.
		for (int i = 0; i < 4; i++) begin
			send_point(mhdsvc_pkg::OP_CONS_TO_PRIM, ext[(i + 1) % 4], ext[i], ext[i], ext[i],
				ext[i], ext[i], ext[i], ext[3 - i]);
			send_point(mhdsvc_pkg::OP_PRIM_TO_CONS, ext[(i + 1) % 4], ext[i], ext[i], ext[i],
				ext[i], ext[i], ext[i], ext[3 - i]);
		end
		send_point(mhdsvc_pkg::OP_CONS_TO_PRIM, 32'h1, 32'h7fffffff, 32'h80000000, 32'h1,
			32'h0, 32'h0, 32'h0, 32'h0);
		send_point(mhdsvc_pkg::OP_PRIM_TO_CONS, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
	endtask

	task automatic test_random(input int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && n > 0; i++, n--)
				send_point(mhdsvc_pkg::op_t'($urandom_range(0, 1)), rand_density(),
					rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word());
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
		end
	endtask

	task automatic test_coefficients();
		logic [31:0] gm[4] = '{32'd1, 32'd131072, 32'd21845, 32'h3ffff};
		logic [31:0] ig[4] = '{32'h7fffffff, 32'd32768, 32'd196608, 32'd0};
		for (int i = 0; i < 4; i++) begin
			drain_pipeline();
			write_coeff(mhdsvc_pkg::REG_GAMMA_M1, gm[i]);
			write_coeff(mhdsvc_pkg::REG_INV_GAMMA_M1, ig[i]);
			test_random(380);
		end
		drain_pipeline();
		write_coeff(mhdsvc_pkg::REG_GAMMA_M1, 32'(mhdsvc_pkg::GMO_RESET));
		write_coeff(mhdsvc_pkg::REG_INV_GAMMA_M1, 32'(mhdsvc_pkg::IGM_RESET));
	endtask

	// Monitor: the receiver cannot stall, so every strobe is a transfer.
	always @(posedge clk) begin
		point_t exp_pt;
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				$error("result with no transfer pending");
				errors++;
			end else begin
				exp_pt = expected_points.pop_front();
				if (x_out !== exp_pt.xv) begin
					$error("x_out expected %h got %h", exp_pt.xv, x_out); errors++;
				end
				if (y_out !== exp_pt.yv) begin
					$error("y_out expected %h got %h", exp_pt.yv, y_out); errors++;
				end
				if (z_out !== exp_pt.zv) begin
					$error("z_out expected %h got %h", exp_pt.zv, z_out); errors++;
				end
				if (energy_or_pressure_out !== exp_pt.ep) begin
					$error("energy_or_pressure_out expected %h got %h", exp_pt.ep,
						energy_or_pressure_out); errors++;
				end
				if (zero_density !== exp_pt.zd) begin
					$error("zero_density expected %b got %b", exp_pt.zd, zero_density);
					errors++;
				end
				if (saturated !== exp_pt.sat) begin
					$error("saturated expected %b got %b", exp_pt.sat, saturated); errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		gmo_copy = mhdsvc_pkg::GMO_RESET;
		igm_copy = mhdsvc_pkg::IGM_RESET;
		{psel, penable, pwrite, start, operation} = '0;
		paddr = '0;
		pwdata = '0;
		{density, x_in, y_in, z_in, field_x, field_y, field_z, energy_or_pressure_in} = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		// Let everything drain once before the random traffic starts.
		drain_pipeline();
		test_random(400);
		test_coefficients();
		drain_pipeline();
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
